// ===== sv/bitmap_min_priority_queue_defines.svh =====
// Assertion helpers used by the bound checker module
`ifndef BITMAP_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define BITMAP_MIN_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BMPQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmpq: check failed");

// Next-cycle implication, disabled while reset is asserted
`define BMPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmpq: check failed");

`endif

// ===== sv/bmpq_pkg.sv =====
package bmpq_pkg;

    // Universe and field widths
    localparam int UNIVERSE  = 1024;
    localparam int ELEM_W    = 10;
    localparam int COUNT_W   = 11;

    // Bitmap organisation: words of presence bits plus a summary word
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = UNIVERSE / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_EXTRACT  = 2'd1,
        FUNC_REMOVE   = 2'd2,
        FUNC_CONTAINS = 2'd3
    } t_func;

    // Error codes
    localparam logic ERR_OK    = 1'b0;
    localparam logic ERR_EMPTY = 1'b1;

    // Input beat
    typedef struct packed {
        t_func              func;
        logic [ELEM_W-1:0]  element;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [ELEM_W-1:0]  min_value;
        logic               found;
        logic               error_code;
        logic [COUNT_W-1:0] element_count;
        logic               is_empty;
    } t_res;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the accepted beat and the word address
        logic rd;      // read the addressed bitmap word
        logic upd;     // modify, write back and produce the result
    } t_ctl;

    // Lowest set bit of a bitmap word
    function automatic logic [BIT_W-1:0] ffs_word(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) idx = BIT_W'(i);
        end
        return idx;
    endfunction

    // Lowest non-empty word from the summary
    function automatic logic [WADDR_W-1:0] ffs_sum(input logic [NUM_WORDS-1:0] s);
        logic [WADDR_W-1:0] idx;
        idx = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (s[i]) idx = WADDR_W'(i);
        end
        return idx;
    endfunction

endpackage

// ===== sv/bmpq_ram.sv =====
module bmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bmpq_ctrl.sv =====
module bmpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output bmpq_pkg::t_ctl o_ctl
);
    import bmpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_READ;
            end
            S_READ: n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    assign o_busy    = (r_state != S_IDLE);
    assign o_ctl.latch = (r_state == S_IDLE) && i_start;
    assign o_ctl.rd    = (r_state == S_READ);
    assign o_ctl.upd   = (r_state == S_UPD);

endmodule

// ===== sv/bmpq_dp.sv =====
module bmpq_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmpq_pkg::t_ctl i_ctl,
    input  bmpq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output bmpq_pkg::t_res o_res
);
    import bmpq_pkg::*;

    // Latched beat and word address
    t_func              r_func;
    logic [ELEM_W-1:0]  r_elem;
    logic [WADDR_W-1:0] r_addr, n_addr;

    // Per-word valid bits and non-empty summary, cleared at reset
    logic [NUM_WORDS-1:0] r_wvalid, r_summary;
    logic [COUNT_W-1:0]   r_count, n_count;

    // Result register
    t_res r_res, n_res;
    logic r_out_valid;

    logic [WORD_W-1:0] ram_rdata, word, n_word;
    logic [BIT_W-1:0]  bit_idx;
    logic              elem_ok, present, do_write;

    // Bitmap word store
    bmpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && do_write),
        .i_waddr (r_addr),
        .i_wdata (n_word),
        .i_re    (i_ctl.rd),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Word address: lowest non-empty word for extract, else the element's word
    always_comb begin
        if (i_cmd.func == FUNC_EXTRACT) begin
            n_addr = ffs_sum(r_summary);
        end else begin
            n_addr = WADDR_W'(i_cmd.element >> BIT_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_func <= i_cmd.func;
            r_elem <= i_cmd.element;
            r_addr <= n_addr;
        end
    end

    // A word never written reads as empty
    assign word    = r_wvalid[r_addr] ? ram_rdata : '0;
    assign elem_ok = 32'(r_elem) < 32'(UNIVERSE);

    // Modify the word and build the result
    always_comb begin
        bit_idx  = (r_func == FUNC_EXTRACT) ? ffs_word(word) : BIT_W'(r_elem);
        present  = word[bit_idx] && elem_ok;
        n_word   = word;
        n_count  = r_count;
        do_write = 1'b0;
        n_res    = '0;
        unique case (r_func)
            FUNC_PUSH: begin
                if (elem_ok && !present) begin
                    n_word[bit_idx] = 1'b1;
                    n_count  = r_count + COUNT_W'(1);
                    do_write = 1'b1;
                end
            end
            FUNC_EXTRACT: begin
                if (|r_summary) begin
                    n_word[bit_idx] = 1'b0;
                    if (r_count != '0) n_count = r_count - COUNT_W'(1);
                    do_write        = 1'b1;
                    n_res.found     = 1'b1;
                    n_res.min_value = ELEM_W'({r_addr, bit_idx});
                end else begin
                    n_res.error_code = ERR_EMPTY;
                end
            end
            FUNC_REMOVE: begin
                if (present) begin
                    n_word[bit_idx] = 1'b0;
                    if (r_count != '0) n_count = r_count - COUNT_W'(1);
                    do_write = 1'b1;
                end
            end
            FUNC_CONTAINS: begin
                n_res.found = present;
            end
            default: ;
        endcase
        if (!n_res.error_code) n_res.error_code = ERR_OK;
        n_res.element_count = n_count;
        n_res.is_empty      = (n_count == '0);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid    <= '0;
            r_summary   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.upd;
            if (i_ctl.upd) begin
                r_count <= n_count;
                if (do_write) begin
                    r_wvalid[r_addr]  <= 1'b1;
                    r_summary[r_addr] <= |n_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) r_res <= n_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/bitmap_min_priority_queue.sv =====
// Each beat passes the read and update states: its bitmap word is read, then
// modified and written back while the result is registered (lowest word picked
// from a summary word). No new beat is taken while busy is high.
// Reset clears the set at once through per-word valid bits; no clearing pass.
// Results are shown for one cycle only; the receiver cannot stall.
module bitmap_min_priority_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  bmpq_pkg::t_cmd i_cmd,
    output logic           busy,
    output logic           o_valid,
    output bmpq_pkg::t_res o_res
);
    import bmpq_pkg::*;

    t_ctl ctl;

    // Sequencer
    bmpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    // Bitmap, summary and count
    bmpq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// ===== sv/bmpq_checker.sv =====
`include "bitmap_min_priority_queue_defines.svh"

module bmpq_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input bmpq_pkg::t_cmd i_cmd,
    input logic           busy,
    input logic           o_valid,
    input bmpq_pkg::t_res o_res
);
    import bmpq_pkg::*;

    // Empty flag agrees with the count
    `BMPQ_ASSERT_IMPL(a_empty_count, o_valid, o_res.is_empty == (o_res.element_count == '0))

    // An accepted beat keeps the block busy next cycle, with no result then
    `BMPQ_ASSERT_NEXT(a_busy_after_start, start && !busy, busy && !o_valid)

    // Found and error never together
    `BMPQ_ASSERT_IMPL(a_found_xor_err, o_valid, !(o_res.found && o_res.error_code))

    // An empty error leaves the queue empty and returns zero
    `BMPQ_ASSERT_IMPL(a_err_empty, o_valid && o_res.error_code,
                      o_res.is_empty && (o_res.min_value == '0))

endmodule

bind bitmap_min_priority_queue bmpq_checker u_bmpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_cmd   (i_cmd),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// ===== bench/pq_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels of the bitmap queue, keeps its own
// copy of the presence set and count, and compares every result beat.
module pq_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  bmpq_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    input  bmpq_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending
);
    import bmpq_pkg::*;

    localparam int REPORT_MAX = 10;

    // Shadow copy of the queue contents
    bit [UNIVERSE-1:0] shadow_present;
    int unsigned       shadow_held;

    // Results still owed by the block, oldest first
    t_res owed_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one operation to the shadow set and return the result it gives
    function automatic t_res apply_queue_op(t_cmd c);
        t_res r;
        bit   hit;
        int   lowest;
        r      = '0;
        hit    = 1'b0;
        lowest = 0;
        case (c.func)
            FUNC_PUSH: begin
                if (!shadow_present[c.element]) begin
                    shadow_present[c.element] = 1'b1;
                    shadow_held++;
                end
            end
            FUNC_EXTRACT: begin
                for (int i = 0; i < UNIVERSE && !hit; i++) begin
                    if (shadow_present[i]) begin
                        hit    = 1'b1;
                        lowest = i;
                    end
                end
                if (hit) begin
                    shadow_present[lowest] = 1'b0;
                    if (shadow_held > 0) shadow_held--;
                    r.min_value = ELEM_W'(lowest);
                    r.found     = 1'b1;
                end else begin
                    r.error_code = ERR_EMPTY;
                end
            end
            FUNC_REMOVE: begin
                if (shadow_present[c.element]) begin
                    shadow_present[c.element] = 1'b0;
                    if (shadow_held > 0) shadow_held--;
                end
            end
            FUNC_CONTAINS: begin
                r.found = shadow_present[c.element];
            end
            default: ;
        endcase
        r.element_count = COUNT_W'(shadow_held);
        r.is_empty      = (shadow_held == 0);
        return r;
    endfunction

    // Log a failure; only the first REPORT_MAX failures are printed
    task automatic note_failure(string what, t_res want, t_res got);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX) begin
            $display("%0t: %s exp min=%0d fnd=%0d err=%0d cnt=%0d emp=%0d",
                     $realtime, what, want.min_value, want.found, want.error_code,
                     want.element_count, want.is_empty);
            $display("%0t: %s got min=%0d fnd=%0d err=%0d cnt=%0d emp=%0d",
                     $realtime, what, got.min_value, got.found, got.error_code,
                     got.element_count, got.is_empty);
        end
    endtask

    // Result beat is checked before the command beat of the same edge
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            shadow_present = '0;
            shadow_held    = 0;
            owed_results.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (owed_results.size() == 0) begin
                    note_failure("unexpected result", '0, i_res);
                end else begin
                    want = owed_results.pop_front();
                    if (i_res.min_value !== want.min_value
                        || i_res.found !== want.found
                        || i_res.error_code !== want.error_code
                        || i_res.element_count !== want.element_count
                        || i_res.is_empty !== want.is_empty)
                        note_failure("result mismatch", want, i_res);
                end
            end
            // Queue the expected result behind those already owed
            if (i_start && !i_busy)
                owed_results.insert(owed_results.size(), apply_queue_op(i_cmd));
        end
        o_pending = owed_results.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bmpq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 12;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    int fail_count;
    int pending_beats;
    int beat_no = 0;

    always #5 i_clk = ~i_clk;

    bitmap_min_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    pq_result_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    function automatic t_cmd make_cmd(t_func f, int unsigned v);
        t_cmd c;
        c.func    = f;
        c.element = ELEM_W'(v);
        return c;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones; every fourth
    // run of 64 beats goes without gaps at all
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (((beat_no / 64) % 4) == 1) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one beat, with noise on the command bus while idle
    task automatic send_beat(t_cmd c);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            i_cmd <= t_cmd'($urandom_range(0, 4095));
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        beat_no++;
    endtask

    // Random operation with weights (percent) and an element drawn from a
    // narrow low band part of the time
    function automatic t_cmd random_cmd(int w_push, int w_ext, int w_rem, int band_pct);
        int unsigned r;
        int unsigned v;
        t_func       f;
        r = $urandom_range(0, 99);
        if (r < w_push)                    f = FUNC_PUSH;
        else if (r < w_push + w_ext)       f = FUNC_EXTRACT;
        else if (r < w_push + w_ext + w_rem) f = FUNC_REMOVE;
        else                               f = FUNC_CONTAINS;
        if ($urandom_range(0, 99) < band_pct) v = $urandom_range(0, 31);
        else                                  v = $urandom_range(0, UNIVERSE - 1);
        return make_cmd(f, v);
    endfunction

    // Run ceiling
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned order[UNIVERSE];
        int unsigned j;
        int unsigned tmp;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, duplicates, absent removes, word edges
        send_beat(make_cmd(FUNC_CONTAINS, 0));
        send_beat(make_cmd(FUNC_EXTRACT, 1023));
        send_beat(make_cmd(FUNC_REMOVE, 7));
        send_beat(make_cmd(FUNC_PUSH, 0));
        send_beat(make_cmd(FUNC_PUSH, 1023));
        send_beat(make_cmd(FUNC_PUSH, 0));
        send_beat(make_cmd(FUNC_CONTAINS, 0));
        send_beat(make_cmd(FUNC_CONTAINS, 1023));
        send_beat(make_cmd(FUNC_CONTAINS, 1022));
        send_beat(make_cmd(FUNC_PUSH, 512));
        send_beat(make_cmd(FUNC_PUSH, 31));
        send_beat(make_cmd(FUNC_PUSH, 32));
        send_beat(make_cmd(FUNC_REMOVE, 512));
        send_beat(make_cmd(FUNC_REMOVE, 512));
        send_beat(make_cmd(FUNC_EXTRACT, 0));
        send_beat(make_cmd(FUNC_EXTRACT, 555));
        send_beat(make_cmd(FUNC_EXTRACT, 1023));
        send_beat(make_cmd(FUNC_EXTRACT, 0));
        send_beat(make_cmd(FUNC_EXTRACT, 0));
        send_beat(make_cmd(FUNC_PUSH, 341));
        send_beat(make_cmd(FUNC_PUSH, 682));
        send_beat(make_cmd(FUNC_CONTAINS, 341));
        send_beat(make_cmd(FUNC_EXTRACT, 0));
        send_beat(make_cmd(FUNC_EXTRACT, 1023));

        // Fill the whole universe in shuffled order so the count reaches 1024
        for (int i = 0; i < UNIVERSE; i++) order[i] = i;
        for (int i = UNIVERSE - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < UNIVERSE; i++) send_beat(make_cmd(FUNC_PUSH, order[i]));
        send_beat(make_cmd(FUNC_PUSH, $urandom_range(0, UNIVERSE - 1)));
        send_beat(make_cmd(FUNC_CONTAINS, $urandom_range(0, UNIVERSE - 1)));

        // Mixed traffic on a densely filled set
        for (int i = 0; i < 400; i++) send_beat(random_cmd(25, 35, 15, 20));

        // Low band, extract heavy: the queue shrinks but never reaches empty
        for (int i = 0; i < 350; i++) send_beat(random_cmd(30, 45, 10, 85));

        @(negedge i_clk);
        start <= 1'b0;

        // Drain, then a short tail for any stray strobe
        while (pending_beats != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_beats == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== bitmap_min_priority_queue.f =====
+incdir+sv
sv/bmpq_pkg.sv
sv/bmpq_ram.sv
sv/bmpq_ctrl.sv
sv/bmpq_dp.sv
sv/bitmap_min_priority_queue.sv
sv/bmpq_checker.sv
bench/pq_result_checker.sv
bench/tb_top.sv
